### design/frms_pkg.sv
`timescale 1ns / 1ps

package frms_pkg;

  // Field widths
  localparam int unsigned TS_W     = 32;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned COEFF_W  = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PERIOD_W = 6;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  // Rate format
  localparam logic [RATE_W-1:0]  RATE_MAX   = '1;
  localparam logic [9:0]         RATE_SCALE = 10'd1000;
  localparam logic [COEFF_W:0]   Q16_ONE    = 17'h10000;
  localparam logic [COEFF_W-1:0] Q16_HALF   = 16'h8000;

  // Item operations
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Smoothing modes
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOWPASS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVG     = 2'd2;

  // Register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_COEFF  = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  // Register reset values
  localparam logic [COEFF_W-1:0]  COEFF_RST  = 16'd52429;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 6'd8;

  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] timestamp_ms;
  } in_t;

  typedef struct packed {
    logic [RATE_W-1:0] fps_raw;
    logic [RATE_W-1:0] fps_smoothed;
    logic              rate_valid;
  } out_t;

endpackage

### design/frms_ram.sv
`timescale 1ns / 1ps

module frms_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

### design/frame_rate_meter_smoothed.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------
// in_      | input     | in_valid/in_stall  | in_t: operation, timestamp_ms
// out_     | output    | out_valid/out_stall| out_t: fps_raw, fps_smoothed, rate_valid
// cfg_     | input     | APB, pready high   | smooth_mode, lowpass_coeff, avg_period
//
// A history-clear item or a frame without a usable time skips the divider entirely.
// A timed frame runs the serial divider with no smoothing, adds the low-pass multiply
// and sum steps once the filter is primed, and a second division of the window sum
// with the moving average; the serial divider yields one quotient bit per cycle.
// The window ring sits in a registered-read RAM; no clearing pass after reset.
// One item is in flight at a time; in_stall is high from acceptance until the result
// is placed in the output register, which a stalled earlier result can hold off.
module frame_rate_meter_smoothed #(
  parameter int unsigned MAX_PERIOD     = 32,
  parameter int unsigned RATE_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  frms_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output frms_pkg::out_t                out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [frms_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [frms_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [frms_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  import frms_pkg::*;

  localparam int unsigned FILL_W = $clog2(MAX_PERIOD + 1);
  localparam int unsigned PTR_W  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int unsigned SUM_W  = RATE_W + FILL_W;
  localparam int unsigned NUM_W  = 10 + RATE_FRAC_BITS;
  localparam int unsigned DIV_W  = ((NUM_W > 31) ? NUM_W : 31) + 1;
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned PW     = (FILL_W > PERIOD_W) ? FILL_W : PERIOD_W;
  localparam int unsigned ACC_W  = RATE_W + COEFF_W;
  localparam int unsigned PROD_W = RATE_W + COEFF_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_LOAD,
    ST_DIV,
    ST_RATE_END,
    ST_LP_MUL0,
    ST_LP_MUL1,
    ST_LP_SUM,
    ST_LP_END,
    ST_AVG_READ,
    ST_AVG_UPD,
    ST_AVG_LOAD,
    ST_AVG_END,
    ST_DONE
  } state_t;

  // Configuration registers
  logic [MODE_W-1:0]   mode_r;
  logic [COEFF_W-1:0]  coeff_r;
  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;
  logic                cfg_hit;

  // Sequencer state and history
  state_t              state_r, state_nxt;
  logic [TS_W-1:0]     last_time_r, last_time_nxt;
  logic [TS_W-1:0]     delta_r, delta_nxt;
  logic [RATE_W-1:0]   fv_r, fv_nxt;
  logic                primed_r, primed_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]    ptr_r, ptr_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  out_t                res_r, res_nxt;
  logic [ACC_W-1:0]    prod_r, prod_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [DIV_W-1:0]    quo_r, quo_nxt;
  logic [TS_W-1:0]     rem_r, rem_nxt;
  logic [TS_W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                avg_div_r, avg_div_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  // Datapath helpers
  logic                in_accept;
  logic                rate_ok;
  logic [TS_W:0]       div_trial;
  logic                div_ge;
  logic [TS_W-1:0]     div_rem;
  logic [RATE_W-1:0]   raw_sat;
  logic [RATE_W-1:0]   mul_a;
  logic [COEFF_W:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PW-1:0]       period_ext;
  logic [FILL_W-1:0]   p_eff;
  logic                win_full;
  logic [FILL_W:0]     old_wide;
  logic [PTR_W-1:0]    old_idx;
  logic [PTR_W-1:0]    ptr_inc;
  logic [RATE_W-1:0]   ram_rd_data;
  logic [RATE_W-1:0]   old_rate;
  logic                ram_rd_en;
  logic                ram_wr_en;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_hit    = cfg_wr && (cfg_paddr[3:2] == REG_MODE || cfg_paddr[3:2] == REG_COEFF ||
                                 cfg_paddr[3:2] == REG_PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NONE;
      coeff_r  <= COEFF_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MODE:   mode_r   <= cfg_pwdata[MODE_W-1:0];
        REG_COEFF:  coeff_r  <= cfg_pwdata[COEFF_W-1:0];
        REG_PERIOD: period_r <= cfg_pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:   cfg_prdata = CFG_DW'(mode_r);
      REG_COEFF:  cfg_prdata = CFG_DW'(coeff_r);
      REG_PERIOD: cfg_prdata = CFG_DW'(period_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Handshake
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rate_ok = (last_time_r != '0) && (last_time_r < in_data.timestamp_ms);

  // Restoring divider step: one quotient bit per cycle
  assign div_trial = {rem_r, quo_r[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, dvs_r});
  assign div_rem   = div_ge ? TS_W'(div_trial - {1'b0, dvs_r}) : div_trial[TS_W-1:0];
  assign raw_sat   = (quo_r > DIV_W'(RATE_MAX)) ? RATE_MAX : quo_r[RATE_W-1:0];

  // Shared multiplier for the low-pass filter
  assign mul_a = (state_r == ST_LP_MUL0) ? fv_r : res_r.fps_raw;
  assign mul_b = (state_r == ST_LP_MUL0) ? {1'b0, coeff_r} : (Q16_ONE - {1'b0, coeff_r});
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Window length, clamped to 1..MAX_PERIOD
  assign period_ext = PW'(period_r);
  always_comb begin
    if (period_r == '0) begin
      p_eff = FILL_W'(1);
    end else if (period_ext > PW'(MAX_PERIOD)) begin
      p_eff = FILL_W'(MAX_PERIOD);
    end else begin
      p_eff = FILL_W'(period_ext);
    end
  end

  // Ring addressing: oldest entry sits fill places behind the write pointer
  assign win_full = (fill_r == p_eff);
  assign old_wide = ((FILL_W + 1)'(ptr_r) >= (FILL_W + 1)'(fill_r)) ?
                    (FILL_W + 1)'(ptr_r) - (FILL_W + 1)'(fill_r) :
                    (FILL_W + 1)'(ptr_r) + (FILL_W + 1)'(MAX_PERIOD) - (FILL_W + 1)'(fill_r);
  assign old_idx  = old_wide[PTR_W-1:0];
  assign ptr_inc  = (ptr_r == PTR_W'(MAX_PERIOD - 1)) ? '0 : ptr_r + 1'b1;

  assign ram_rd_en = (state_r == ST_AVG_READ) && win_full;
  assign ram_wr_en = (state_r == ST_AVG_UPD);
  assign old_rate  = win_full ? ram_rd_data : '0;

  frms_ram #(
    .WIDTH (RATE_W),
    .DEPTH (MAX_PERIOD)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ptr_r),
    .wr_data (res_r.fps_raw),
    .rd_en   (ram_rd_en),
    .rd_addr (old_idx),
    .rd_data (ram_rd_data)
  );

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    delta_nxt     = delta_r;
    fv_nxt        = fv_r;
    primed_nxt    = primed_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    avg_div_nxt   = avg_div_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop a result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.operation == OP_CLEAR) begin
            last_time_nxt = '0;
            fv_nxt        = '0;
            primed_nxt    = 1'b0;
            fill_nxt      = '0;
            ptr_nxt       = '0;
            sum_nxt       = '0;
            res_nxt       = '0;
            state_nxt     = ST_DONE;
          end else begin
            last_time_nxt = in_data.timestamp_ms;
            delta_nxt     = in_data.timestamp_ms - last_time_r;
            res_nxt       = '0;
            state_nxt     = rate_ok ? ST_RATE_LOAD : ST_DONE;
          end
        end
      end

      // Rounded quotient: (scale + delta/2) / delta
      ST_RATE_LOAD: begin
        quo_nxt     = (DIV_W'(RATE_SCALE) << RATE_FRAC_BITS) + DIV_W'(delta_r >> 1);
        rem_nxt     = '0;
        dvs_nxt     = delta_r;
        cnt_nxt     = CNT_W'(DIV_W);
        avg_div_nxt = 1'b0;
        state_nxt   = ST_DIV;
      end

      ST_DIV: begin
        rem_nxt = div_rem;
        quo_nxt = {quo_r[DIV_W-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = avg_div_r ? ST_AVG_END : ST_RATE_END;
        end
      end

      ST_RATE_END: begin
        res_nxt.fps_raw    = raw_sat;
        res_nxt.rate_valid = 1'b1;
        case (mode_r)
          MODE_LOWPASS: begin
            if (primed_r) begin
              state_nxt = ST_LP_MUL0;
            end else begin
              fv_nxt               = raw_sat;
              primed_nxt           = 1'b1;
              res_nxt.fps_smoothed = raw_sat;
              state_nxt            = ST_DONE;
            end
          end
          MODE_AVG: begin
            state_nxt = ST_AVG_READ;
          end
          default: begin
            res_nxt.fps_smoothed = raw_sat;
            state_nxt            = ST_DONE;
          end
        endcase
      end

      // Low-pass: (fv*c + x*(1-c) + half) >> 16
      ST_LP_MUL0: begin
        prod_nxt  = mul_p[ACC_W-1:0];
        state_nxt = ST_LP_MUL1;
      end

      ST_LP_MUL1: begin
        acc_nxt   = prod_r + ACC_W'(Q16_HALF);
        prod_nxt  = mul_p[ACC_W-1:0];
        state_nxt = ST_LP_SUM;
      end

      ST_LP_SUM: begin
        acc_nxt   = acc_r + prod_r;
        state_nxt = ST_LP_END;
      end

      ST_LP_END: begin
        fv_nxt               = acc_r[ACC_W-1 -: RATE_W];
        res_nxt.fps_smoothed = acc_r[ACC_W-1 -: RATE_W];
        state_nxt            = ST_DONE;
      end

      // Moving average: fetch the leaving entry, then update ring and sum
      ST_AVG_READ: begin
        state_nxt = ST_AVG_UPD;
      end

      ST_AVG_UPD: begin
        sum_nxt   = sum_r - SUM_W'(old_rate) + SUM_W'(res_r.fps_raw);
        fill_nxt  = win_full ? fill_r : fill_r + 1'b1;
        ptr_nxt   = ptr_inc;
        state_nxt = ST_AVG_LOAD;
      end

      ST_AVG_LOAD: begin
        quo_nxt     = {SUM_W'(sum_r + SUM_W'(fill_r >> 1)), {(DIV_W - SUM_W){1'b0}}};
        rem_nxt     = '0;
        dvs_nxt     = TS_W'(fill_r);
        cnt_nxt     = CNT_W'(SUM_W);
        avg_div_nxt = 1'b1;
        state_nxt   = ST_DIV;
      end

      ST_AVG_END: begin
        res_nxt.fps_smoothed = quo_r[RATE_W-1:0];
        state_nxt            = ST_DONE;
      end

      // Hold the result until the output register is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A register write clears smoothing history, not the last time
    if (cfg_hit) begin
      fv_nxt     = '0;
      primed_nxt = 1'b0;
      fill_nxt   = '0;
      ptr_nxt    = '0;
      sum_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_time_r <= '0;
      fv_r        <= '0;
      primed_r    <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      avg_div_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_time_r <= last_time_nxt;
      fv_r        <= fv_nxt;
      primed_r    <= primed_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      sum_r       <= sum_nxt;
      avg_div_r   <= avg_div_nxt;
      out_valid_r <= out_valid_nxt;
    end
    delta_r    <= delta_nxt;
    res_r      <= res_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= p_eff)
    else $error("window fill exceeds window length");

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(MAX_PERIOD - 1))
    else $error("write pointer beyond ring");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.operation == OP_CLEAR) |=>
      (last_time_r == '0 && fill_r == '0 && !primed_r && sum_r == '0))
    else $error("history not cleared by clear item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.rate_valid) |->
      (out_data.fps_raw == '0 && out_data.fps_smoothed == '0))
    else $error("rates nonzero without a valid rate");
`endif

endmodule
